@@ sv/avdb_pkg.sv @@
// Shared types and fixed constants of the audio dB level meter.
// No dependencies; imported by avdb_div, audio_volume_db_meter_core and testbench, used by the scoreboard.
package avdb_pkg;

    // dB values are Q7.8 signed
    localparam logic signed [15:0] DB_FLOOR = -16'sd23040;
    localparam logic signed [15:0] DB_CEIL  = 16'sd23295;
    localparam logic signed [15:0] DB_MAX   = 16'sd32767;

    // 20*log10(2) in Q16
    localparam logic [31:0] LOG_DB_Q16 = 32'd394566;

    // damping ratio, Q4.12 unsigned
    localparam logic [15:0] RATIO_RESET = 16'd410;
    localparam logic [15:0] RATIO_RISE  = 16'd41;
    localparam logic [15:0] RATIO_MAX   = 16'd32768;

    // reciprocals: floor(x/191) = (x*RECIP_191)>>32 for x < 2^24,
    // floor(x/10) = (x*RECIP_10)>>22 for x < 2^19
    localparam logic [31:0] RECIP_191 = 32'd22486740;
    localparam logic [31:0] RECIP_10  = 32'd419431;

    // envelope floor threshold: env*100000 < 768*full_scale
    localparam logic [31:0] FLOOR_SCALE = 32'd100000;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNELS   = 2'd0;
    localparam logic [1:0] CFG_WINDOW_LEN = 2'd1;
    localparam logic [1:0] CFG_FULL_SCALE = 2'd2;

    typedef struct packed {
        logic start;
        logic neg;
    } avdb_div_req_t;

    typedef struct packed {
        logic done;
    } avdb_div_rsp_t;

endpackage

@@ sv/avdb_div.sv @@
// Bit-serial restoring divider with floor rounding for signed numerators.
// Depends on avdb_pkg for the request and response structs.
module avdb_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  avdb_pkg::avdb_div_req_t req,
    input  logic [NUM_W-1:0]       num_mag,
    input  logic [DEN_W-1:0]       den,
    output avdb_pkg::avdb_div_rsp_t rsp,
    output logic signed [NUM_W:0]  quot
);
    import avdb_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             take;
    logic [NUM_W:0]   q_ext;

    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        take      = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_W);
            neg_next  = req.neg;
            num_next  = num_mag;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // shift one quotient bit in per cycle
            num_next = {num_reg[NUM_W-2:0], take};
            rem_next = take ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // floor toward minus infinity for a negative numerator
    always_comb
    begin
        q_ext = {1'b0, num_reg};
        if (neg_reg)
            quot = -$signed(q_ext + (NUM_W+1)'(rem_reg != '0));
        else
            quot = $signed(q_ext);
    end

    assign rsp.done = done_reg;

endmodule

@@ sv/audio_volume_db_meter_core.sv @@
// Top level of the audio dB level meter: envelope, log, window mean, damping.
// Depends on avdb_pkg and avdb_div.
// Flow: a word that is not on channel 0 only advances the phase; if it ends a buffer, the
//   damping step emits its result, with ratio and drop steps added on a falling level. A
//   channel 0 word holds the input through the decay (on a decay), the floor test, and the
//   normalizing shifts and squarings on the shared 32x32 multiplier, skipped below the
//   floor; a closing window adds a divider run, ending a buffer adds the damping step.
// Reset: asynchronous active low on the control registers; payload registers are not reset.
module audio_volume_db_meter_core #(
    parameter int LOG_TABLE_BITS = 10,
    parameter int MAX_WINDOW     = 192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] level_db
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import avdb_pkg::*;

    localparam int R_W   = LOG_TABLE_BITS + 5;
    localparam int L_W   = LOG_TABLE_BITS + 7;
    localparam int SQ_W  = $clog2(LOG_TABLE_BITS + 1);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = $clog2(MAX_WINDOW) + 17;
    localparam int N_W   = SUM_W + 2;
    localparam int D_W   = CNT_W + 1;

    localparam logic [R_W-1:0]        R_START = R_W'(30);
    localparam logic signed [L_W-1:0] L_BIAS  = L_W'(8 << LOG_TABLE_BITS);
    localparam logic [63:0]           DB_HALF = 64'd1 << (LOG_TABLE_BITS + 7);
    localparam logic signed [17:0]    FLOOR18 = 18'(DB_FLOOR);
    localparam logic signed [17:0]    CEIL18  = 18'(DB_CEIL);
    localparam logic signed [N_W:0]   FLOOR_N = (N_W+1)'(DB_FLOOR);
    localparam logic signed [N_W:0]   MAX_N   = (N_W+1)'(DB_MAX);

    typedef enum logic [17:0] {
        S_IDLE   = 18'd1,
        S_DECAY  = 18'd2,
        S_DECAY2 = 18'd4,
        S_FLOOR  = 18'd8,
        S_FLOOR2 = 18'd16,
        S_NORM   = 18'd32,
        S_SQ     = 18'd64,
        S_SQ2    = 18'd128,
        S_LOGEND = 18'd256,
        S_DB     = 18'd512,
        S_DB2    = 18'd1024,
        S_ACC    = 18'd2048,
        S_DIV    = 18'd4096,
        S_LAST   = 18'd8192,
        S_RATIO2 = 18'd16384,
        S_DROP   = 18'd32768,
        S_DROP2  = 18'd65536,
        S_EMIT   = 18'd131072
    } state_t;

    // control state
    state_t                  state_reg, state_next;
    logic [3:0]              channels_reg, channels_next;
    logic [7:0]              wlen_reg, wlen_next;
    logic [15:0]             fs_reg, fs_next;
    logic [2:0]              phase_reg, phase_next;
    logic [23:0]             env_reg, env_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [15:0]      mean_reg, mean_next;
    logic signed [15:0]      prev_reg, prev_next;
    logic [15:0]             ratio_reg, ratio_next;
    logic                    out_valid_reg, out_valid_next;

    // payload and working registers
    logic                    last_reg, last_next;
    logic [63:0]             prod_reg;
    logic [30:0]             lg_m_reg, lg_m_next;
    logic [R_W-1:0]          lg_r_reg, lg_r_next;
    logic [SQ_W-1:0]         sq_cnt_reg, sq_cnt_next;
    logic                    lg_sel_reg, lg_sel_next;
    logic [R_W-1:0]          log_env_reg, log_env_next;
    logic                    l_neg_reg, l_neg_next;
    logic [L_W-1:0]          l_mag_reg, l_mag_next;
    logic signed [15:0]      db_reg, db_next;
    logic [15:0]             diff_reg, diff_next;
    logic signed [15:0]      cur_reg, cur_next;
    logic [15:0]             out_data_reg, out_data_next;

    // shared multiplier operands
    logic [31:0]             mul_a, mul_b;

    // derived values
    logic [3:0]              ch_eff;
    logic [15:0]             wl16;
    logic [CNT_W-1:0]        wl_eff;
    logic [15:0]             fs_eff;
    logic                    picked;
    logic [3:0]              ph_inc;
    logic [16:0]             smp_abs;
    logic [23:0]             mag24;
    logic [23:0]             dec_q;
    logic [31:0]             dec_q191;
    logic [31:0]             dec_rem;
    logic [63:0]             floor_thr;
    logic [31:0]             sq_val;
    logic signed [L_W-1:0]   l_val;
    logic [63:0]             db_rnd;
    logic [63:0]             db_q;
    logic [15:0]             db_sat;
    logic signed [15:0]      db_val;
    logic signed [SUM_W-1:0] sum_new;
    logic [CNT_W-1:0]        cnt_new;
    logic signed [N_W-1:0]   n_val;
    logic [N_W-1:0]          n_mag;
    logic signed [N_W:0]     quot;
    logic signed [15:0]      mean_val;
    logic signed [16:0]      diff_val;
    logic [18:0]             ratio_grow;
    logic [18:0]             ratio_q;
    logic [63:0]             drop_full;
    logic [16:0]             drop17;
    logic signed [17:0]      cur_wide;
    logic signed [15:0]      cur_rise;

    avdb_div_req_t           div_req;
    avdb_div_rsp_t           div_rsp;

    avdb_div #(
        .NUM_W (N_W),
        .DEN_W (D_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .num_mag (n_mag),
        .den     ({cnt_new, 1'b0}),
        .rsp     (div_rsp),
        .quot    (quot)
    );

    // register clamps and per-word arithmetic
    always_comb
    begin
        ch_eff = (channels_reg == 4'd0) ? 4'd1 :
                 ((channels_reg > 4'd8) ? 4'd8 : channels_reg);
        wl16   = (wlen_reg == 8'd0) ? 16'd1 : {8'd0, wlen_reg};
        if (wl16 > 16'(MAX_WINDOW))
            wl16 = 16'(MAX_WINDOW);
        wl_eff = CNT_W'(wl16);
        fs_eff = (fs_reg == 16'd0) ? 16'd1 : fs_reg;

        picked  = (phase_reg == 3'd0);
        ph_inc  = {1'b0, phase_reg} + 4'd1;
        smp_abs = s_axis_tdata[15] ? (17'd0 - {1'b0, s_axis_tdata})
                                   : {1'b0, s_axis_tdata};
        mag24   = {smp_abs[15:0], 8'd0};

        // env*190/191 floored is env minus ceil(env/191)
        dec_q    = prod_reg[55:32];
        dec_q191 = {dec_q, 8'd0} - {2'd0, dec_q, 6'd0} - {8'd0, dec_q};
        dec_rem  = {8'd0, env_reg} - dec_q191;

        floor_thr = ({48'd0, fs_eff} << 9) + ({48'd0, fs_eff} << 8);
        sq_val    = prod_reg[61:30];

        l_val = $signed(L_W'(log_env_reg)) - $signed(L_W'(lg_r_reg)) - L_BIAS;

        db_rnd = prod_reg + DB_HALF;
        db_q   = db_rnd >> (LOG_TABLE_BITS + 8);
        db_sat = (db_q > 64'd32767) ? 16'h7fff : db_q[15:0];
        db_val = l_neg_reg ? -$signed(db_sat) : $signed(db_sat);

        sum_new = sum_reg + SUM_W'(db_reg);
        cnt_new = cnt_reg + 1'b1;
        n_val   = (N_W'(sum_new) <<< 1) + $signed(N_W'(cnt_new));
        n_mag   = n_val[N_W-1] ? N_W'(-n_val) : N_W'(n_val);

        if (quot < FLOOR_N)
            mean_val = DB_FLOOR;
        else if (quot > MAX_N)
            mean_val = DB_MAX;
        else
            mean_val = quot[15:0];

        diff_val   = 17'(prev_reg) - 17'(mean_reg);
        ratio_grow = {ratio_reg, 3'd0} + {1'b0, ratio_reg, 2'd0} + 19'd5;
        ratio_q    = prod_reg[40:22];

        drop_full = (prod_reg + 64'd2048) >> 12;
        drop17    = (drop_full > 64'd65536) ? 17'h10000 : drop_full[16:0];
        cur_wide  = 18'(prev_reg) - $signed({1'b0, drop17});
        cur_rise  = (mean_reg > DB_CEIL) ? DB_CEIL : mean_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        channels_next  = channels_reg;
        wlen_next      = wlen_reg;
        fs_next        = fs_reg;
        phase_next     = phase_reg;
        env_next       = env_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        mean_next      = mean_reg;
        prev_next      = prev_reg;
        ratio_next     = ratio_reg;
        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        lg_m_next      = lg_m_reg;
        lg_r_next      = lg_r_reg;
        sq_cnt_next    = sq_cnt_reg;
        lg_sel_next    = lg_sel_reg;
        log_env_next   = log_env_reg;
        l_neg_next     = l_neg_reg;
        l_mag_next     = l_mag_reg;
        db_next        = db_reg;
        diff_next      = diff_reg;
        cur_next       = cur_reg;
        out_data_next  = out_data_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNELS:   channels_next = cfg_wdata[3:0];
                CFG_WINDOW_LEN: wlen_next     = cfg_wdata[7:0];
                CFG_FULL_SCALE: fs_next       = cfg_wdata;
                default:        ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    // phase past the channel count falls back to zero
                    phase_next = (ph_inc >= ch_eff) ? 3'd0 : ph_inc[2:0];
                    last_next  = s_axis_tlast;
                    if (picked)
                    begin
                        if (mag24 > env_reg)
                        begin
                            env_next   = mag24;
                            state_next = S_FLOOR;
                        end
                        else
                            state_next = S_DECAY;
                    end
                    else if (s_axis_tlast)
                        state_next = S_LAST;
                end
            end
            S_DECAY:
            begin
                mul_a      = {8'd0, env_reg};
                mul_b      = RECIP_191;
                state_next = S_DECAY2;
            end
            S_DECAY2:
            begin
                env_next   = env_reg - dec_q - 24'(dec_rem != 32'd0);
                state_next = S_FLOOR;
            end
            S_FLOOR:
            begin
                mul_a      = {8'd0, env_reg};
                mul_b      = FLOOR_SCALE;
                state_next = S_FLOOR2;
            end
            S_FLOOR2:
            begin
                if (prod_reg < floor_thr)
                begin
                    db_next    = DB_FLOOR;
                    state_next = S_ACC;
                end
                else
                begin
                    lg_m_next   = {7'd0, env_reg};
                    lg_r_next   = R_START;
                    lg_sel_next = 1'b0;
                    state_next  = S_NORM;
                end
            end
            S_NORM:
            begin
                // bring the leading one to bit 30, a byte at a time when possible
                if (lg_m_reg[30])
                begin
                    sq_cnt_next = '0;
                    state_next  = S_SQ;
                end
                else if (lg_m_reg[30:23] == 8'd0)
                begin
                    lg_m_next = lg_m_reg << 8;
                    lg_r_next = lg_r_reg - R_W'(8);
                end
                else
                begin
                    lg_m_next = lg_m_reg << 1;
                    lg_r_next = lg_r_reg - R_W'(1);
                end
            end
            S_SQ:
            begin
                mul_a      = {1'b0, lg_m_reg};
                mul_b      = {1'b0, lg_m_reg};
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                // one fraction bit per squaring
                lg_r_next   = {lg_r_reg[R_W-2:0], sq_val[31]};
                lg_m_next   = sq_val[31] ? sq_val[31:1] : sq_val[30:0];
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == SQ_W'(LOG_TABLE_BITS - 1))
                    state_next = S_LOGEND;
                else
                    state_next = S_SQ;
            end
            S_LOGEND:
            begin
                if (!lg_sel_reg)
                begin
                    log_env_next = lg_r_reg;
                    lg_m_next    = {15'd0, fs_eff};
                    lg_r_next    = R_START;
                    lg_sel_next  = 1'b1;
                    state_next   = S_NORM;
                end
                else
                begin
                    l_neg_next = l_val[L_W-1];
                    l_mag_next = l_val[L_W-1] ? L_W'(-l_val) : L_W'(l_val);
                    state_next = S_DB;
                end
            end
            S_DB:
            begin
                mul_a      = 32'(l_mag_reg);
                mul_b      = LOG_DB_Q16;
                state_next = S_DB2;
            end
            S_DB2:
            begin
                db_next    = db_val;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = sum_new;
                cnt_next = cnt_new;
                if (cnt_new >= wl_eff)
                begin
                    div_req.start = 1'b1;
                    div_req.neg   = n_val[N_W-1];
                    state_next    = S_DIV;
                end
                else
                    state_next = S_LAST;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    mean_next  = mean_val;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                mul_a = 32'(ratio_grow);
                mul_b = RECIP_10;
                if (!last_reg)
                    state_next = S_IDLE;
                else if (diff_val > 17'sd0)
                begin
                    diff_next  = diff_val[15:0];
                    state_next = S_RATIO2;
                end
                else
                begin
                    // level not falling: follow at once and restart damping
                    ratio_next = RATIO_RISE;
                    cur_next   = cur_rise;
                    state_next = S_EMIT;
                end
            end
            S_RATIO2:
            begin
                ratio_next = (ratio_q > 19'(RATIO_MAX)) ? RATIO_MAX : ratio_q[15:0];
                state_next = S_DROP;
            end
            S_DROP:
            begin
                mul_a      = {16'd0, diff_reg};
                mul_b      = {16'd0, ratio_reg};
                state_next = S_DROP2;
            end
            S_DROP2:
            begin
                if (cur_wide < FLOOR18)
                    cur_next = DB_FLOOR;
                else if (cur_wide > CEIL18)
                    cur_next = DB_CEIL;
                else
                    cur_next = cur_wide[15:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = cur_reg;
                    prev_next      = cur_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            channels_reg  <= 4'd1;
            wlen_reg      <= 8'd48;
            fs_reg        <= 16'h8000;
            phase_reg     <= 3'd0;
            env_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            mean_reg      <= DB_FLOOR;
            prev_reg      <= DB_FLOOR;
            ratio_reg     <= RATIO_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            channels_reg  <= channels_next;
            wlen_reg      <= wlen_next;
            fs_reg        <= fs_next;
            phase_reg     <= phase_next;
            env_reg       <= env_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            mean_reg      <= mean_next;
            prev_reg      <= prev_next;
            ratio_reg     <= ratio_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= 64'(mul_a) * 64'(mul_b);
        last_reg     <= last_next;
        lg_m_reg     <= lg_m_next;
        lg_r_reg     <= lg_r_next;
        sq_cnt_reg   <= sq_cnt_next;
        lg_sel_reg   <= lg_sel_next;
        log_env_reg  <= log_env_next;
        l_neg_reg    <= l_neg_next;
        l_mag_reg    <= l_mag_next;
        db_reg       <= db_next;
        diff_reg     <= diff_next;
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_WINDOW))
        else $error("window count beyond maximum window");

    a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ratio_reg <= RATIO_MAX)
        else $error("damping ratio above its limit");

    a_prev_range: assert property (@(posedge clk) disable iff (!rst_n)
        prev_reg >= DB_FLOOR && prev_reg <= DB_CEIL)
        else $error("previous level out of range");

    a_emit_word: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && (!out_valid_reg || m_axis_tready)
        |=> m_axis_tvalid && m_axis_tdata == $past(cur_reg))
        else $error("emitted word lost or changed");
`endif

endmodule

@@ bench/audio_volume_db_meter_core_sb.sv @@
// Scoreboard for the audio dB level meter: bit-accurate level predictor and result checker.
// Depends on avdb_pkg for the dB, ratio, log and register index constants.
`timescale 1ns / 100ps

class avdb_level_scoreboard;
    localparam int LOG_BITS = 10;
    localparam int WIN_MAX  = 192;

    logic [3:0]  reg_channels;
    logic [7:0]  reg_window_len;
    logic [15:0] reg_full_scale;

    logic [31:0] envelope;
    longint      window_sum;
    int          window_count;
    int          mean_level;
    int          previous_level;
    longint      damp_ratio;
    int          channel_phase;

    logic signed [15:0] pending_levels[$];
    int mismatches;

    function new();
        reg_channels   = 4'd1;
        reg_window_len = 8'd48;
        reg_full_scale = 16'h8000;
        envelope       = 0;
        window_sum     = 0;
        window_count   = 0;
        mean_level     = int'(avdb_pkg::DB_FLOOR);
        previous_level = int'(avdb_pkg::DB_FLOOR);
        damp_ratio     = longint'(avdb_pkg::RATIO_RESET);
        channel_phase  = 0;
        mismatches     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
        case (idx)
            avdb_pkg::CFG_CHANNELS:   reg_channels   = value[3:0];
            avdb_pkg::CFG_WINDOW_LEN: reg_window_len = value[7:0];
            avdb_pkg::CFG_FULL_SCALE: reg_full_scale = value;
            default: ;
        endcase
    endfunction

    // log2 with LOG_BITS fraction bits by repeated squaring, truncated
    function longint log2_q(longint x);
        longint e, t, r;
        logic [63:0] m;
        e = 0;
        t = x;
        while (t > 1) begin t = t >> 1; e++; end
        m = 64'(x) << (30 - e);
        r = e;
        for (int i = 0; i < LOG_BITS; i++) begin
            m = (m * m) >> 30;
            r = r * 2;
            if (m >= 64'h8000_0000) begin r += 1; m = m >> 1; end
        end
        return r;
    endfunction

    function longint envelope_db(longint env, longint fs);
        longint l, mag, q;
        if (env * 100000 < 768 * fs) return longint'(avdb_pkg::DB_FLOOR);
        l = log2_q(env) - log2_q(fs) - 8 * (longint'(1) << LOG_BITS);
        mag = (l < 0 ? -l : l) * longint'(avdb_pkg::LOG_DB_Q16);
        q = (mag + (longint'(1) << (LOG_BITS + 7))) >> (LOG_BITS + 8);
        if (q > 32767) q = 32767;
        return l < 0 ? -q : q;
    endfunction

    // note one accepted sample word and, if it ends a buffer, queue the level it produces
    function void note_sample(logic signed [15:0] sample, logic last);
        longint ch, wl, fs, mag, n, d, q, cur, diff, r, drop;
        ch = reg_channels == 0 ? 1 : (reg_channels > 8 ? 8 : reg_channels);
        wl = reg_window_len == 0 ? 1 : reg_window_len;
        if (wl > WIN_MAX) wl = WIN_MAX;
        fs = reg_full_scale == 0 ? 1 : reg_full_scale;
        if (channel_phase == 0) begin
            mag = (sample < 0 ? -longint'(sample) : longint'(sample)) << 8;
            if (mag > envelope) envelope = 32'(mag);
            else envelope = 32'((longint'(envelope) * 190) / 191);
            window_sum += envelope_db(envelope, fs);
            window_count++;
            if (window_count >= wl) begin
                n = 2 * window_sum + window_count;
                d = 2 * window_count;
                q = n / d;
                if (n % d != 0 && n < 0) q--;
                if (q < avdb_pkg::DB_FLOOR) q = avdb_pkg::DB_FLOOR;
                if (q > 32767) q = 32767;
                mean_level   = int'(q);
                window_sum   = 0;
                window_count = 0;
            end
        end
        channel_phase = (channel_phase + 1 >= ch) ? 0 : channel_phase + 1;
        if (!last) return;
        cur  = mean_level;
        diff = previous_level - cur;
        if (diff > 0) begin
            r = (damp_ratio * 12 + 5) / 10;
            damp_ratio = r > 32768 ? 32768 : r;
            drop = (diff * damp_ratio + 2048) >> 12;
            if (drop > 65536) drop = 65536;
            cur = previous_level - drop;
        end else begin
            damp_ratio = longint'(avdb_pkg::RATIO_RISE);
        end
        if (cur < avdb_pkg::DB_FLOOR) cur = avdb_pkg::DB_FLOOR;
        if (cur > avdb_pkg::DB_CEIL) cur = avdb_pkg::DB_CEIL;
        previous_level = int'(cur);
        pending_levels.push_back(16'(cur));
    endfunction

    function void check_level(logic signed [15:0] level);
        logic signed [15:0] want;
        if (pending_levels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected level word %0d", level);
            return;
        end
        want = pending_levels.pop_front();
        if (level !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("level_db mismatch: expected %0d actual %0d", want, level);
        end
    endfunction
endclass

@@ bench/testbench.sv @@
// Top-level testbench of audio_volume_db_meter_core: drives sample words and
// register writes, checks every level word. Depends on avdb_pkg and the scoreboard.
`timescale 1ns / 100ps

module testbench;
    import avdb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [15:0] sample
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [15:0] level_db
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    avdb_level_scoreboard level_sb = new();
    int  idle_cycles = 0;
    bit  timed_out = 1'b0;
    bit  sink_steady = 1'b0;

    always #5 clk = ~clk;

    audio_volume_db_meter_core u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Check level words at the rising edge; count handshake-free cycles.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                level_sb.check_level(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: drop ready at random before each word, sometimes hold ready high throughout.
    initial begin
        int gap;
        forever begin
            @(negedge clk);
            if (sink_steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                gap = $urandom_range(0, 8);
                if (gap == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                    m_axis_tready <= 1'b1;
                end
                // hold ready until one word moves
                @(posedge clk);
                while (!m_axis_tvalid) @(posedge clk);
            end
        end
    end

    // Write one register while the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        level_sb.write_reg(idx, value);
    endtask

    // Present one sample word, optionally after a random gap; hold until accepted.
    task automatic send_sample(logic [15:0] sample, logic last, bit use_gap);
        int gap;
        gap = use_gap ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        level_sb.note_sample(sample, last);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Drain outstanding levels, then let the pipeline settle before a register write.
    task automatic drain_levels();
        while (level_sb.pending_levels.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Random sample: mostly uniform random words, sometimes the extremes or near-silent values.
    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 31)) ^ {16{$urandom_range(0, 1) == 1}};
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int sent;
        int buf_len;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, silence floor, rising and falling levels, non-first channel.
        send_sample(16'h7FFF, 1'b1, 1'b0);
        send_sample(16'h8000, 1'b1, 1'b0);
        drain_levels();
        write_reg(CFG_WINDOW_LEN, 16'd1);
        send_sample(16'h0000, 1'b1, 1'b0);
        send_sample(16'h8000, 1'b1, 1'b1);
        send_sample(16'h0001, 1'b0, 1'b1);
        send_sample(16'hFFFF, 1'b1, 1'b1);
        for (int i = 0; i < 6; i++) send_sample(16'h0000, 1'b1, 1'b1);
        drain_levels();
        write_reg(CFG_CHANNELS, 16'd8);
        write_reg(CFG_FULL_SCALE, 16'd1);
        send_sample(16'h4000, 1'b0, 1'b1);
        send_sample(16'h7FFF, 1'b1, 1'b1);
        send_sample(16'h0002, 1'b1, 1'b1);
        drain_levels();
        // phase may now exceed the channel count
        write_reg(CFG_CHANNELS, 16'd0);
        write_reg(CFG_WINDOW_LEN, 16'd0);
        write_reg(CFG_FULL_SCALE, 16'd0);
        send_sample(16'h1234, 1'b1, 1'b1);
        send_sample(16'h0100, 1'b1, 1'b1);
        drain_levels();
        write_reg(CFG_CHANNELS, 16'd15);
        write_reg(CFG_WINDOW_LEN, 16'd255);
        send_sample(16'hC000, 1'b1, 1'b1);
        drain_levels();

        // Random phases: new settings between them, buffers of random length.
        sent = 0;
        for (int phase = 0; sent < 850; phase++) begin
            write_reg(CFG_CHANNELS, 16'($urandom_range(0, 15)));
            write_reg(CFG_WINDOW_LEN, (phase % 4 == 0) ? 16'd192 :
                      16'($urandom_range(0, 12)));
            write_reg(CFG_FULL_SCALE, (phase % 3 == 0) ? 16'h8000 : 16'($urandom));
            sink_steady = (phase % 5 == 1);
            for (int b = 0; b < 6; b++) begin
                buf_len = $urandom_range(1, 10);
                for (int k = 0; k < buf_len; k++) begin
                    send_sample(random_sample(), k == buf_len - 1, phase % 5 != 2);
                    sent++;
                end
            end
            if (phase % 3 == 0) while (level_sb.pending_levels.size() != 0) @(posedge clk);
            drain_levels();
        end
        sink_steady = 1'b0;

        drain_levels();
        if (level_sb.mismatches == 0 && level_sb.pending_levels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/avdb_pkg.sv
sv/avdb_div.sv
sv/audio_volume_db_meter_core.sv
bench/audio_volume_db_meter_core_sb.sv
bench/testbench.sv
